FILE: src/srfcc_pkg.sv
// Shared types and constants for the sensor reply framer with CRC check.
// No dependencies; imported by the interfaces' users and all modules.
package srfcc_pkg;

  localparam int unsigned MAX_REPLY_DEF       = 64;
  localparam int unsigned BODY_TIMEOUT_MS_DEF = 1000;

  localparam logic [15:0] CRC_INIT    = 16'hFFFF;
  localparam logic [15:0] CRC_POLY    = 16'hA001;
  localparam logic [7:0]  START_BYTE  = 8'hFE;
  localparam logic [6:0]  MIN_LENGTH  = 7'd4;

  // operation codes on the command channel
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_BYTE  = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  // event codes on the event channel
  localparam logic [2:0] EV_STORED        = 3'd0;
  localparam logic [2:0] EV_CRC_OK        = 3'd1;
  localparam logic [2:0] EV_CRC_FAIL      = 3'd2;
  localparam logic [2:0] EV_START_TIMEOUT = 3'd3;
  localparam logic [2:0] EV_BODY_TIMEOUT  = 3'd4;

  // configuration register indexes
  localparam logic REG_REPLY_LENGTH  = 1'b0;
  localparam logic REG_START_TIMEOUT = 1'b1;

  localparam logic [6:0]  REPLY_LENGTH_RST  = 7'd4;
  localparam logic [15:0] START_TIMEOUT_RST = 16'd1000;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_HUNT = 2'd1,
    PH_BODY = 2'd2
  } phase_t;

  typedef struct packed {
    logic [6:0]  reply_length;
    logic [15:0] start_timeout_ms;
  } cfg_t;

endpackage

FILE: src/srfcc_if.sv
// Valid/ready channel interfaces for command words and event words.
// Standalone; used by the top level and the frame controller.
interface srfcc_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] rx_byte;

  modport source(output valid, operation, rx_byte, input ready);
  modport sink(input valid, operation, rx_byte, output ready);
endinterface

interface srfcc_evt_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_res;
  logic [7:0] data_byte;
  logic [5:0] byte_index;

  modport source(output valid, event_res, data_byte, byte_index, input ready);
  modport sink(input valid, event_res, data_byte, byte_index, output ready);
endinterface

FILE: src/srfcc_crc_byte.sv
// Modbus CRC-16 update over one byte, LSB first, reflected poly 0xA001.
// Depends on srfcc_pkg.
module srfcc_crc_byte
  import srfcc_pkg::*;
(
  input  logic [15:0] crc_in,
  input  logic [7:0]  data,
  output logic [15:0] crc_out
);

  always_comb begin
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    crc_out = c;
  end

endmodule

FILE: src/srfcc_frame_ctrl.sv
// Framing state, CRC accumulation, timeouts and the event output register.
// Depends on srfcc_pkg, srfcc_if and srfcc_crc_byte.
module srfcc_frame_ctrl
  import srfcc_pkg::*;
#(
  parameter int unsigned MAX_REPLY       = MAX_REPLY_DEF,
  parameter int unsigned BODY_TIMEOUT_MS = BODY_TIMEOUT_MS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  srfcc_cmd_if.sink   cmd,
  srfcc_evt_if.source evt
);

  localparam int CW = $clog2(MAX_REPLY + 1);
  localparam int LW = (CW > 7) ? CW : 7;
  localparam logic [LW-1:0] MAX_L       = LW'(MAX_REPLY);
  localparam logic [CW-1:0] LAST_IDX    = CW'(MAX_REPLY - 1);
  localparam logic [15:0]   BODY_LIMIT  = 16'(BODY_TIMEOUT_MS);

  phase_t      phase, phase_next;
  logic [CW-1:0] count, count_next;
  logic [15:0] running_crc, crc_next;
  logic [15:0] elapsed, elapsed_next;
  logic        low_ok, low_ok_next;

  logic        evt_valid;
  logic [2:0]  ev_code;
  logic [7:0]  ev_data;
  logic [5:0]  ev_idx;
  logic        emit;
  logic        fire;

  logic [15:0]   crc_seed, crc_fed;
  logic [LW-1:0] len_wide;
  logic [CW-1:0] eff_len;
  logic [CW-1:0] idx;
  logic [CW:0]   idx_p1, idx_p2;
  logic [CW+5:0] idx_wide;
  logic [15:0]   elapsed_inc;

  assign cmd.ready = !evt_valid || evt.ready;
  assign fire      = cmd.valid && cmd.ready;

  // clamp the configured length into 4 .. MAX_REPLY
  always_comb begin
    len_wide = LW'(cfg.reply_length);
    if (len_wide < LW'(MIN_LENGTH)) begin
      len_wide = LW'(MIN_LENGTH);
    end else if (len_wide > MAX_L) begin
      len_wide = MAX_L;
    end
    eff_len = len_wide[CW-1:0];
  end

  assign idx      = (count >= CW'(MAX_REPLY)) ? LAST_IDX : count;
  assign idx_p1   = {1'b0, idx} + (CW+1)'(1);
  assign idx_p2   = {1'b0, idx} + (CW+1)'(2);
  assign idx_wide = {6'd0, idx};

  assign elapsed_inc = (elapsed == 16'hFFFF) ? elapsed : elapsed + 16'd1;

  assign crc_seed = (phase == PH_HUNT) ? CRC_INIT : running_crc;

  srfcc_crc_byte u_crc (
    .crc_in  (crc_seed),
    .data    (cmd.rx_byte),
    .crc_out (crc_fed)
  );

  always_comb begin
    phase_next   = phase;
    count_next   = count;
    crc_next     = running_crc;
    elapsed_next = elapsed;
    low_ok_next  = low_ok;
    emit         = 1'b0;
    ev_code      = EV_STORED;
    ev_data      = cmd.rx_byte;
    ev_idx       = idx_wide[5:0];
    case (cmd.operation)
      OP_START: begin
        phase_next   = PH_HUNT;
        count_next   = '0;
        crc_next     = CRC_INIT;
        elapsed_next = '0;
        low_ok_next  = 1'b0;
      end
      OP_BYTE: begin
        if (phase == PH_HUNT) begin
          if (cmd.rx_byte == START_BYTE) begin
            phase_next   = PH_BODY;
            count_next   = CW'(1);
            crc_next     = crc_fed;
            elapsed_next = '0;
            emit         = 1'b1;
            ev_idx       = '0;
          end
        end else if (phase == PH_BODY) begin
          count_next = idx_p1[CW-1:0];
          emit       = 1'b1;
          if (idx_p1 >= {1'b0, eff_len}) begin
            // final byte: high CRC byte check
            phase_next = PH_IDLE;
            ev_code    = (low_ok && cmd.rx_byte == running_crc[15:8]) ?
                         EV_CRC_OK : EV_CRC_FAIL;
          end else if (idx_p2 == {1'b0, eff_len}) begin
            low_ok_next = (cmd.rx_byte == running_crc[7:0]);
          end else begin
            crc_next = crc_fed;
          end
        end
      end
      OP_TICK: begin
        if (phase != PH_IDLE) begin
          elapsed_next = elapsed_inc;
          if (phase == PH_HUNT && elapsed_inc >= cfg.start_timeout_ms) begin
            phase_next = PH_IDLE;
            emit       = 1'b1;
            ev_code    = EV_START_TIMEOUT;
          end else if (phase == PH_BODY && elapsed_inc >= BODY_LIMIT) begin
            phase_next = PH_IDLE;
            emit       = 1'b1;
            ev_code    = EV_BODY_TIMEOUT;
          end
          ev_data = '0;
          ev_idx  = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      count       <= '0;
      running_crc <= CRC_INIT;
      elapsed     <= '0;
      low_ok      <= 1'b0;
    end else if (fire) begin
      phase       <= phase_next;
      count       <= count_next;
      running_crc <= crc_next;
      elapsed     <= elapsed_next;
      low_ok      <= low_ok_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      evt_valid <= 1'b0;
    end else if (fire) begin
      evt_valid <= emit;
    end else if (evt.ready) begin
      evt_valid <= 1'b0;
    end
  end

  // event payload, loaded only with a new word
  always_ff @(posedge clk) begin
    if (fire && emit) begin
      evt.event_res  <= ev_code;
      evt.data_byte  <= ev_data;
      evt.byte_index <= ev_idx;
    end
  end

  assign evt.valid = evt_valid;

endmodule

FILE: src/sensor_reply_framer_crc_check_unit.sv
// Top level of the sensor reply framer with Modbus CRC-16 check.
// Depends on srfcc_pkg, srfcc_if, srfcc_frame_ctrl.
//
// Usage:
//   cmd  : command words in (operation, rx_byte); OP_START arms hunting for
//          the 0xFE start byte, OP_BYTE delivers a received byte, OP_TICK is
//          one millisecond tick.
//   evt  : event words out (event_res, data_byte, byte_index): one per stored
//          byte, the last one carrying CRC pass/fail, or a timeout event.
//   cfg  : write port; index 0 reply_length, index 1 start_timeout_ms.
//          Write only while the block is idle.
// Timing: a command word is taken at any edge where cmd.ready is high; its
//   event word is valid on the next cycle. One word per cycle sustained while
//   evt.ready keeps up: the CRC byte update and the framing decision are
//   combinational between the command handshake and the event output register.
// Stall: while an event word waits on evt.ready, cmd.ready stays high only
//   if that word is taken in the same cycle.
// Reset (rst, synchronous): idle phase, CRC 0xFFFF, counters cleared,
//   reply_length 4, start_timeout_ms 1000, no event pending.
module sensor_reply_framer_crc_check_unit
  import srfcc_pkg::*;
#(
  parameter int unsigned MAX_REPLY       = MAX_REPLY_DEF,
  parameter int unsigned BODY_TIMEOUT_MS = BODY_TIMEOUT_MS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  srfcc_cmd_if.sink   cmd,
  srfcc_evt_if.source evt
);

  cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.reply_length     <= REPLY_LENGTH_RST;
      cfg.start_timeout_ms <= START_TIMEOUT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_REPLY_LENGTH:  cfg.reply_length     <= cfg_data[6:0];
        REG_START_TIMEOUT: cfg.start_timeout_ms <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  srfcc_frame_ctrl #(
    .MAX_REPLY       (MAX_REPLY),
    .BODY_TIMEOUT_MS (BODY_TIMEOUT_MS)
  ) u_ctrl (
    .clk (clk),
    .rst (rst),
    .cfg (cfg),
    .cmd (cmd),
    .evt (evt)
  );

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// Testbench for sensor_reply_framer_crc_check_unit: a directed table, then random
// frames; every event word is checked against a given word or the predictor.
// Depends on srfcc_pkg, srfcc_if and the RTL top level.
module tb_top;
  import srfcc_pkg::*;

  localparam logic [1:0]  OP_UNUSED = 2'd3;
  localparam int unsigned MAX_BYTES = MAX_REPLY_DEF;

  typedef struct packed {
    logic [2:0] ev;
    logic [7:0] data;
    logic [5:0] idx;
  } evt_word_t;

  typedef enum logic [1:0] {ROW_WORD, ROW_LEN, ROW_TIMEOUT} row_kind_t;
  typedef enum logic [1:0] {SRC_LIT, SRC_CRC_LO, SRC_CRC_HI} byte_src_t;
  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_GIVEN} row_chk_t;

  // val is the byte for word rows (xor mask on CRC rows), the value for writes
  typedef struct packed {
    row_kind_t  kind;
    logic [1:0] op;
    byte_src_t  src;
    logic [15:0] val;
    row_chk_t   chk;
    evt_word_t  want;
  } dir_row_t;

  localparam evt_word_t NO_EVT = '0;
  localparam int DIR_ROWS = 29;
  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    '{ROW_WORD, OP_TICK, SRC_LIT, 16'h0000, CHK_NONE, NO_EVT},
    '{ROW_WORD, OP_BYTE, SRC_LIT, 16'h00FE, CHK_NONE, NO_EVT},
    '{ROW_WORD, OP_UNUSED, SRC_LIT, 16'h00FE, CHK_NONE, NO_EVT},
    '{ROW_WORD, OP_START, SRC_LIT, 16'h0000, CHK_NONE, NO_EVT},
    '{ROW_WORD, OP_BYTE, SRC_LIT, 16'h0000, CHK_NONE, NO_EVT},
    '{ROW_WORD, OP_BYTE, SRC_LIT, 16'h00FF, CHK_NONE, NO_EVT},
    '{ROW_WORD, OP_BYTE, SRC_LIT, 16'h00FE, CHK_GIVEN, '{EV_STORED, 8'hFE, 6'd0}},
    '{ROW_WORD, OP_BYTE, SRC_LIT, 16'h0012, CHK_GIVEN, '{EV_STORED, 8'h12, 6'd1}},
    '{ROW_WORD, OP_BYTE, SRC_CRC_LO, 16'h0000, CHK_MODEL, NO_EVT},
    '{ROW_WORD, OP_BYTE, SRC_CRC_HI, 16'h0000, CHK_MODEL, NO_EVT},
    '{ROW_WORD, OP_START, SRC_LIT, 16'h00FF, CHK_NONE, NO_EVT},
    '{ROW_WORD, OP_BYTE, SRC_LIT, 16'h00FE, CHK_GIVEN, '{EV_STORED, 8'hFE, 6'd0}},
    '{ROW_WORD, OP_BYTE, SRC_LIT, 16'h0080, CHK_GIVEN, '{EV_STORED, 8'h80, 6'd1}},
    // bad low CRC byte, good high byte
    '{ROW_WORD, OP_BYTE, SRC_CRC_LO, 16'h0001, CHK_MODEL, NO_EVT},
    '{ROW_WORD, OP_BYTE, SRC_CRC_HI, 16'h0000, CHK_MODEL, NO_EVT},
    // zero start timeout fires on the first tick
    '{ROW_TIMEOUT, OP_START, SRC_LIT, 16'h0000, CHK_NONE, NO_EVT},
    '{ROW_WORD, OP_START, SRC_LIT, 16'h0000, CHK_NONE, NO_EVT},
    '{ROW_WORD, OP_TICK, SRC_LIT, 16'h00FF, CHK_GIVEN, '{EV_START_TIMEOUT, 8'h00, 6'd0}},
    '{ROW_WORD, OP_TICK, SRC_LIT, 16'h0000, CHK_NONE, NO_EVT},
    // length shrunk mid-frame: the next byte is taken as the last one
    '{ROW_LEN, OP_START, SRC_LIT, 16'd10, CHK_NONE, NO_EVT},
    '{ROW_WORD, OP_START, SRC_LIT, 16'h0000, CHK_NONE, NO_EVT},
    '{ROW_WORD, OP_BYTE, SRC_LIT, 16'h00FE, CHK_GIVEN, '{EV_STORED, 8'hFE, 6'd0}},
    '{ROW_WORD, OP_BYTE, SRC_LIT, 16'h007F, CHK_GIVEN, '{EV_STORED, 8'h7F, 6'd1}},
    '{ROW_WORD, OP_BYTE, SRC_LIT, 16'h0055, CHK_GIVEN, '{EV_STORED, 8'h55, 6'd2}},
    '{ROW_LEN, OP_START, SRC_LIT, 16'd0, CHK_NONE, NO_EVT},
    '{ROW_WORD, OP_BYTE, SRC_LIT, 16'h00AA, CHK_MODEL, NO_EVT},
    '{ROW_TIMEOUT, OP_START, SRC_LIT, 16'h0001, CHK_NONE, NO_EVT},
    '{ROW_WORD, OP_START, SRC_LIT, 16'h0000, CHK_NONE, NO_EVT},
    '{ROW_WORD, OP_TICK, SRC_LIT, 16'h0000, CHK_GIVEN, '{EV_START_TIMEOUT, 8'h00, 6'd0}}
  };

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic        cfg_index;
  logic [15:0] cfg_data;

  srfcc_cmd_if cmd();
  srfcc_evt_if evt();

  sensor_reply_framer_crc_check_unit uut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .cmd(cmd),
    .evt(evt)
  );

  // frame predictor state and its copy of the registers
  phase_t      fr_phase    = PH_IDLE;
  logic [6:0]  fr_count    = '0;
  logic [15:0] fr_crc      = CRC_INIT;
  logic [15:0] fr_elapsed  = '0;
  logic        fr_low_ok   = 1'b0;
  logic [6:0]  reg_len     = REPLY_LENGTH_RST;
  logic [15:0] reg_timeout = START_TIMEOUT_RST;

  evt_word_t   pending_events[$];
  int unsigned fail_count    = 0;
  int unsigned words_used    = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int          hold_left     = 0;

  function automatic logic [15:0] crc16_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {8'h00, b};
    for (int k = 0; k < 8; k++)
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    return r;
  endfunction

  function automatic logic [6:0] reply_len();
    if (reg_len < MIN_LENGTH) return MIN_LENGTH;
    if (reg_len > 7'(MAX_BYTES)) return 7'(MAX_BYTES);
    return reg_len;
  endfunction

  function automatic void frame_step(input logic [1:0] op, input logic [7:0] b,
                                     output logic fired, output evt_word_t w,
                                     output logic used);
    logic [6:0] len;
    logic [6:0] pos;
    fired = 1'b0;
    used  = 1'b0;
    w     = NO_EVT;
    len   = reply_len();
    case (op)
      OP_START: begin
        fr_phase   = PH_HUNT;
        fr_count   = '0;
        fr_crc     = CRC_INIT;
        fr_elapsed = '0;
        fr_low_ok  = 1'b0;
        used       = 1'b1;
      end
      OP_BYTE: begin
        if (fr_phase == PH_HUNT && b == START_BYTE) begin
          fr_crc     = crc16_byte(CRC_INIT, b);
          fr_count   = 7'd1;
          fr_elapsed = '0;
          fr_phase   = PH_BODY;
          used       = 1'b1;
          fired      = 1'b1;
          w          = '{EV_STORED, b, 6'd0};
        end else if (fr_phase == PH_BODY) begin
          pos    = (fr_count >= 7'(MAX_BYTES)) ? 7'(MAX_BYTES - 1) : fr_count;
          used   = 1'b1;
          fired  = 1'b1;
          w.data = b;
          w.idx  = pos[5:0];
          if (pos + 7'd1 >= len) begin
            w.ev     = (fr_low_ok && b == fr_crc[15:8]) ? EV_CRC_OK : EV_CRC_FAIL;
            fr_phase = PH_IDLE;
          end else begin
            w.ev = EV_STORED;
            // second to last byte is the low CRC byte, not fed to the CRC
            if (pos + 7'd2 == len) fr_low_ok = (b == fr_crc[7:0]);
            else fr_crc = crc16_byte(fr_crc, b);
          end
          fr_count = pos + 7'd1;
        end
      end
      OP_TICK: begin
        if (fr_phase != PH_IDLE) begin
          used = 1'b1;
          if (fr_elapsed != 16'hFFFF) fr_elapsed = fr_elapsed + 16'd1;
          if (fr_phase == PH_HUNT && fr_elapsed >= reg_timeout) begin
            fr_phase = PH_IDLE;
            fired    = 1'b1;
            w        = '{EV_START_TIMEOUT, 8'h00, 6'd0};
          end else if (fr_phase == PH_BODY && fr_elapsed >= BODY_TIMEOUT_MS_DEF) begin
            fr_phase = PH_IDLE;
            fired    = 1'b1;
            w        = '{EV_BODY_TIMEOUT, 8'h00, 6'd0};
          end
        end
      end
      default: ;
    endcase
  endfunction

  task automatic send_word(input logic [1:0] op, input logic [7:0] b,
                           input row_chk_t chk, input evt_word_t want);
    logic      fired;
    logic      used;
    evt_word_t got;
    while ($urandom_range(99) < send_idle_pct) begin
      cmd.valid <= 1'b0;
      @(posedge clk);
    end
    cmd.valid     <= 1'b1;
    cmd.operation <= op;
    cmd.rx_byte   <= b;
    @(posedge clk);
    while (!cmd.ready) @(posedge clk);
    frame_step(op, b, fired, got, used);
    if (used) words_used++;
    if (chk == CHK_GIVEN) pending_events.push_back(want);
    else if (chk == CHK_MODEL && fired) pending_events.push_back(got);
  endtask

  // drop valid and wait until every expected event word is out
  task automatic settle();
    cmd.valid <= 1'b0;
    @(posedge clk);
    while (pending_events.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic sel, input logic [15:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (sel == REG_START_TIMEOUT) reg_timeout = value;
    else reg_len = value[6:0];
  endtask

  task automatic send_noise();
    logic [7:0] b;
    b = 8'($urandom);
    case ($urandom_range(2))
      0: send_word(OP_BYTE, (b == START_BYTE) ? ~b : b, CHK_MODEL, NO_EVT);
      1: send_word(OP_TICK, b, CHK_MODEL, NO_EVT);
      default: send_word(OP_UNUSED, b, CHK_MODEL, NO_EVT);
    endcase
  endtask

  // one reply: start (not always), some hunting noise, 0xFE, body, CRC bytes;
  // sometimes truncated, corrupted or timed out while hunting
  task automatic send_frame();
    int unsigned len;
    int unsigned cut;
    logic [7:0]  b;
    if ($urandom_range(99) < 95) send_word(OP_START, 8'($urandom), CHK_MODEL, NO_EVT);
    repeat ($urandom_range(0, 3)) send_noise();
    if ($urandom_range(99) < 10)
      repeat ($urandom_range(1, 12)) send_word(OP_TICK, 8'($urandom), CHK_MODEL, NO_EVT);
    send_word(OP_BYTE, START_BYTE, CHK_MODEL, NO_EVT);
    len = reply_len();
    cut = ($urandom_range(99) < 8) ? $urandom_range(1, len - 1) : len;
    for (int i = 1; i < cut; i++) begin
      if ($urandom_range(99) < 4)
        repeat ($urandom_range(1, 3)) send_word(OP_TICK, 8'($urandom), CHK_MODEL, NO_EVT);
      if (i == len - 2)
        b = fr_crc[7:0] ^ (($urandom_range(99) < 10) ? 8'($urandom_range(1, 255)) : 8'h00);
      else if (i == len - 1)
        b = fr_crc[15:8] ^ (($urandom_range(99) < 10) ? 8'($urandom_range(1, 255)) : 8'h00);
      else
        b = 8'($urandom);
      send_word(OP_BYTE, b, CHK_MODEL, NO_EVT);
    end
    if ($urandom_range(99) < 15) send_noise();
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("FAIL sensor_reply_framer_crc_check_unit");
    $finish;
  end

  // event sink: check each taken word, then pick ready for the next edge
  initial begin
    evt_word_t want;
    evt.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && evt.valid && evt.ready) begin
        if (pending_events.size() == 0) begin
          fail_count++;
          $display("%0t: expected no event word, actual ev=%0d data=%h idx=%0d", $time,
                   evt.event_res, evt.data_byte, evt.byte_index);
        end else begin
          want = pending_events.pop_front();
          if (evt.event_res !== want.ev) begin
            fail_count++;
            $display("%0t: event_res expected %0d actual %0d", $time, want.ev,
                     evt.event_res);
          end
          if (evt.data_byte !== want.data) begin
            fail_count++;
            $display("%0t: data_byte expected %h actual %h", $time, want.data,
                     evt.data_byte);
          end
          if (evt.byte_index !== want.idx) begin
            fail_count++;
            $display("%0t: byte_index expected %0d actual %0d", $time, want.idx,
                     evt.byte_index);
          end
        end
      end
      if (hold_left > 0) begin
        evt.ready <= 1'b0;
        hold_left--;
      end else begin
        evt.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    dir_row_t    row;
    logic [7:0]  b;
    int unsigned r;
    int unsigned chunk_start;
    rst           <= 1'b1;
    cfg_we        <= 1'b0;
    cfg_index     <= REG_REPLY_LENGTH;
    cfg_data      <= '0;
    cmd.valid     <= 1'b0;
    cmd.operation <= OP_START;
    cmd.rx_byte   <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < DIR_ROWS; i++) begin
      row = DIR_TABLE[i];
      if (row.kind != ROW_WORD) begin
        settle();
        write_reg((row.kind == ROW_TIMEOUT) ? REG_START_TIMEOUT : REG_REPLY_LENGTH, row.val);
      end else begin
        b = row.val[7:0];
        if (row.src == SRC_CRC_LO) b = b ^ fr_crc[7:0];
        else if (row.src == SRC_CRC_HI) b = b ^ fr_crc[15:8];
        send_word(row.op, b, row.chk, row.want);
      end
    end

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 32 : (ph == 1) ? 78 : 0;
      recv_idle_pct = (ph == 0) ? 78 : (ph == 1) ? 32 : 0;
      words_used = 0;
      while (words_used < 240) begin
        settle();
        r = $urandom_range(99);
        write_reg(REG_REPLY_LENGTH, (r < 5) ? 16'd0 : (r < 10) ? 16'd127 :
                  (r < 16) ? 16'd64 : (r < 22) ? 16'd3 : 16'($urandom_range(4, 12)));
        r = $urandom_range(99);
        write_reg(REG_START_TIMEOUT, (r < 10) ? 16'd0 : (r < 20) ? 16'd1 :
                  16'($urandom_range(2, 12)));
        // long sink stall while words keep coming: input must back up
        if (ph == 0 && words_used == 0) hold_left = 400;
        chunk_start = words_used;
        while (words_used < chunk_start + 60) send_frame();
      end
    end

    // start timer at its largest value
    settle();
    write_reg(REG_START_TIMEOUT, 16'hFFFF);
    send_word(OP_START, 8'h00, CHK_MODEL, NO_EVT);
    repeat (8) send_word(OP_TICK, 8'($urandom), CHK_MODEL, NO_EVT);

    // body timer runs out in a long frame
    settle();
    write_reg(REG_REPLY_LENGTH, 16'd64);
    send_word(OP_START, 8'h00, CHK_MODEL, NO_EVT);
    send_word(OP_BYTE, START_BYTE, CHK_MODEL, NO_EVT);
    repeat (5) send_word(OP_BYTE, 8'($urandom), CHK_MODEL, NO_EVT);
    repeat (BODY_TIMEOUT_MS_DEF) send_word(OP_TICK, 8'($urandom), CHK_MODEL, NO_EVT);

    settle();
    if (fail_count == 0)
      $display("PASS sensor_reply_framer_crc_check_unit");
    else
      $display("FAIL sensor_reply_framer_crc_check_unit");
    $finish;
  end

endmodule
